[hw/rtl/qmr_pkg.sv]
// Shared types, constants and term tables for the quaternion multiply/rotate core.
package qmr_pkg;

	localparam int COMP_W = 32;
	localparam int PROD_W = 2 * COMP_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int FRAC_W = 16;
	localparam int SHR_W  = SUM_W - FRAC_W;

	localparam logic [1:0] X_IDX = 2'd0;
	localparam logic [1:0] Y_IDX = 2'd1;
	localparam logic [1:0] Z_IDX = 2'd2;
	localparam logic [1:0] W_IDX = 2'd3;

	localparam logic [0:0] OP_MUL = 1'b0;
	localparam logic [0:0] OP_ROT = 1'b1;

	localparam logic signed [COMP_W-1:0] ONE     = 32'sh0001_0000;
	localparam logic signed [COMP_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COMP_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef logic [3:0][COMP_W-1:0] quat_t;

	typedef struct packed {
		logic  op;
		quat_t a;
		logic  ovf;
	} side_t;

	typedef struct packed {
		quat_t res;
		logic  ovf;
	} out_t;

	// Hamilton product p*q: component k sums p[TERM_P]*q[TERM_Q], negated where TERM_NEG.
	localparam logic [1:0] TERM_P [4][4] = '{
		'{W_IDX, X_IDX, Y_IDX, Z_IDX},
		'{W_IDX, Y_IDX, Z_IDX, X_IDX},
		'{W_IDX, Z_IDX, X_IDX, Y_IDX},
		'{W_IDX, X_IDX, Y_IDX, Z_IDX}
	};
	localparam logic [1:0] TERM_Q [4][4] = '{
		'{X_IDX, W_IDX, Z_IDX, Y_IDX},
		'{Y_IDX, W_IDX, X_IDX, Z_IDX},
		'{Z_IDX, W_IDX, Y_IDX, X_IDX},
		'{W_IDX, X_IDX, Y_IDX, Z_IDX}
	};
	localparam logic TERM_NEG [4][4] = '{
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b1, 1'b1}
	};

	function automatic logic signed [PAIR_W-1:0] signed_term(
		input logic signed [PROD_W-1:0] v,
		input logic                     n
	);
		logic signed [PAIR_W-1:0] e;
		e = PAIR_W'(v);
		return n ? -e : e;
	endfunction

endpackage

[hw/rtl/qmr_qmul.sv]
// Three-stage fixed-point Hamilton product with optional conjugate of q and saturation.
module qmr_qmul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  qmr_pkg::quat_t p,
	input  qmr_pkg::quat_t q,
	input  logic           conj,
	input  qmr_pkg::side_t side_in,
	output logic           out_valid,
	output qmr_pkg::quat_t res,
	output logic [3:0]     sat,
	output qmr_pkg::side_t side_out
);
	import qmr_pkg::*;

	logic v_s1, v_s2, v_s3;
	side_t side_s1, side_s2, side_s3;
	logic conj_s1;
	logic signed [PROD_W-1:0] prod_s1 [4][4];
	logic signed [PAIR_W-1:0] pair_s2 [4][2];
	quat_t res_s3;
	logic [3:0] sat_s3;

	logic signed [PAIR_W-1:0] pair_d [4][2];
	logic signed [SUM_W-1:0]  sum_d [4];
	logic signed [SHR_W-1:0]  shr_d [4];
	quat_t res_d;
	logic [3:0] sat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				for (int t = 0; t < 4; t++) begin
					prod_s1[k][t] <= $signed(p[TERM_P[k][t]]) * $signed(q[TERM_Q[k][t]]);
				end
			end
			conj_s1 <= conj;
			side_s1 <= side_in;
			pair_s2 <= pair_d;
			side_s2 <= side_s1;
			res_s3  <= res_d;
			sat_s3  <= sat_d;
			side_s3 <= side_s2;
		end
	end

	// conjugate of q flips the sign of every term that uses its vector part
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int h = 0; h < 2; h++) begin
				pair_d[k][h] =
					signed_term(prod_s1[k][2*h],
						TERM_NEG[k][2*h] ^ (conj_s1 && TERM_Q[k][2*h] != W_IDX)) +
					signed_term(prod_s1[k][2*h+1],
						TERM_NEG[k][2*h+1] ^ (conj_s1 && TERM_Q[k][2*h+1] != W_IDX));
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_d[k] = SUM_W'(pair_s2[k][0]) + SUM_W'(pair_s2[k][1]);
			shr_d[k] = SHR_W'(sum_d[k] >>> FRAC_W);
			sat_d[k] = !((&shr_d[k][SHR_W-1:COMP_W-1]) || !(|shr_d[k][SHR_W-1:COMP_W-1]));
			if (sat_d[k]) begin
				res_d[k] = shr_d[k][SHR_W-1] ? SAT_MIN : SAT_MAX;
			end else begin
				res_d[k] = shr_d[k][COMP_W-1:0];
			end
		end
	end

	assign out_valid = v_s3;
	assign res       = res_s3;
	assign sat       = sat_s3;
	assign side_out  = side_s3;

endmodule

[hw/rtl/qmr_skid.sv]
// Output register with skid slot; upstream ready comes from a flop.
module qmr_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qmr_pkg::out_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qmr_pkg::out_t out_data
);
	import qmr_pkg::*;

	logic out_valid_q, skid_valid_q;
	out_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_data;
		end
	end

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/quaternion_multiply_rotate_core.sv]
// An accepted input beat passes two chained 3-stage product units, 16 multipliers each,
// then the output register. Throughput: one beat per cycle while the skid slot is empty.
// Multiply passes the first product through the second unit times the identity quaternion.
// Ready to the source is a flop: it drops only while the output skid slot is occupied.
// Reset (arst_n low) clears all valid bits, including the output valid; data is not reset.
module quaternion_multiply_rotate_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
	input  logic [0:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // res_x, res_y, res_z, res_w
	output logic [0:0]   m_tuser   // overflow
);
	import qmr_pkg::*;

	logic en;
	logic rot;
	quat_t a_in, b_in, q1, q2, t1, r2;
	side_t side1_in, side1_out, side2_in, side2_out;
	logic v1, v2;
	logic [3:0] sat1, sat2;
	out_t fin;

	assign rot  = (s_tuser == OP_ROT);
	assign a_in = s_tdata[127:0];
	assign b_in = s_tdata[255:128];

	always_comb begin
		q1 = b_in;
		if (rot) begin
			q1[W_IDX] = '0;
		end
	end

	assign side1_in = '{op: rot, a: a_in, ovf: 1'b0};

	qmr_qmul u_qmul_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.p        (a_in),
		.q        (q1),
		.conj     (1'b0),
		.side_in  (side1_in),
		.out_valid(v1),
		.res      (t1),
		.sat      (sat1),
		.side_out (side1_out)
	);

	always_comb begin
		q2 = '0;
		q2[W_IDX] = ONE;
		if (side1_out.op) begin
			q2 = side1_out.a;
		end
	end

	assign side2_in = '{op: side1_out.op, a: side1_out.a, ovf: |sat1};

	qmr_qmul u_qmul_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v1),
		.p        (t1),
		.q        (q2),
		.conj     (side1_out.op),
		.side_in  (side2_in),
		.out_valid(v2),
		.res      (r2),
		.sat      (sat2),
		.side_out (side2_out)
	);

	always_comb begin
		fin.res = r2;
		fin.ovf = side2_out.ovf | (|sat2[2:0]);
		if (side2_out.op) begin
			fin.res[W_IDX] = '0;
		end else begin
			fin.ovf = fin.ovf | sat2[3];
		end
	end

	qmr_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v2),
		.in_ready (en),
		.in_data  (fin),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data ({m_tdata, m_tuser})
	);

	assign s_tready = en;

endmodule
